/* src/rc5d_pkg.sv */
// Package: shared types, constants and the helper function of the RC5 edge timing decoder.
`timescale 1ns / 1ps
`default_nettype none
package rc5d_pkg;

   localparam int COUNT_WIDTH  = 24;
   localparam int ADDRESS_BITS = 5;
   localparam int COMMAND_BITS = 6;
   localparam int REPEAT_WIDTH = 8;
   localparam int PHASE_WIDTH  = 3;
   localparam int BITPOS_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   // decoder phases
   localparam logic [PHASE_WIDTH-1:0] PHASE_START1  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_START2  = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_TOGGLE  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_ADDRESS = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PHASE_COMMAND = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_BIT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_EN  = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] BIT_PERIOD_RESET = 24'd1778;
   localparam logic [COUNT_WIDTH-1:0] HALF_BIT_RESET   = 24'd889;
   localparam logic [COUNT_WIDTH-1:0] TOLERANCE_RESET  = 24'd240;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = '1;

   localparam logic [BITPOS_WIDTH-1:0] ADDRESS_LAST = BITPOS_WIDTH'(ADDRESS_BITS);
   localparam logic [BITPOS_WIDTH-1:0] COMMAND_LAST = BITPOS_WIDTH'(COMMAND_BITS);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] bit_period_ticks;
      logic [COUNT_WIDTH-1:0] half_bit_ticks;
      logic [COUNT_WIDTH-1:0] tolerance_ticks;
      logic                   repeat_detect_enable;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]  phase;
      logic [COUNT_WIDTH-1:0]  tick_count;
      logic [BITPOS_WIDTH-1:0] bit_position;
      logic [ADDRESS_BITS-1:0] address_shift;
      logic [COMMAND_BITS-1:0] command_shift;
      logic                    current_toggle;
      logic                    previous_toggle;
      logic [REPEAT_WIDTH-1:0] repeats;
   } dec_state_type;

   typedef struct packed {
      logic                   mode;
      logic                   line_low;
      logic [COUNT_WIDTH-1:0] elapsed_ticks;
   } req_word_type;

   // |cnt - nominal| < tol
   function automatic logic near_value(input logic [COUNT_WIDTH-1:0] cnt,
                                       input logic [COUNT_WIDTH-1:0] nominal,
                                       input logic [COUNT_WIDTH-1:0] tol);
      logic [COUNT_WIDTH:0] diff;
      logic [COUNT_WIDTH:0] mag;
      diff = {1'b0, cnt} - {1'b0, nominal};
      mag  = diff[COUNT_WIDTH] ? (~diff + 1'b1) : diff;
      return mag < {1'b0, tol};
   endfunction

endpackage
`default_nettype wire

/* src/rc5d_req_if.sv */
// Interface: input edge-event channel of the RC5 decoder.
`timescale 1ns / 1ps
`default_nettype none
interface rc5d_req_if
   import rc5d_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic                   line_low;
   logic [COUNT_WIDTH-1:0] elapsed_ticks;

   modport source (output valid, output mode, output line_low, output elapsed_ticks,
                   input ready);
   modport sink (input valid, input mode, input line_low, input elapsed_ticks,
                 output ready);
endinterface
`default_nettype wire

/* src/rc5d_rsp_if.sv */
// Interface: result channel of the RC5 decoder.
`timescale 1ns / 1ps
`default_nettype none
interface rc5d_rsp_if
   import rc5d_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic                    frame_valid;
   logic [ADDRESS_BITS-1:0] address;
   logic [COMMAND_BITS-1:0] command;
   logic                    toggle_bit;
   logic [REPEAT_WIDTH-1:0] repeat_count;
   logic [PHASE_WIDTH-1:0]  decoder_phase;

   modport source (output valid, output frame_valid, output address, output command,
                   output toggle_bit, output repeat_count, output decoder_phase,
                   input ready);
   modport sink (input valid, input frame_valid, input address, input command,
                 input toggle_bit, input repeat_count, input decoder_phase,
                 output ready);
endinterface
`default_nettype wire

/* src/rc5d_csr.sv */
// Module: configuration registers of the RC5 decoder.
`timescale 1ns / 1ps
`default_nettype none
module rc5d_csr
   import rc5d_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COUNT_WIDTH-1:0]     csr_write_data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_PERIOD: cfg_in.bit_period_ticks     = csr_write_data;
            CSR_HALF_BIT:   cfg_in.half_bit_ticks       = csr_write_data;
            CSR_TOLERANCE:  cfg_in.tolerance_ticks      = csr_write_data;
            CSR_REPEAT_EN:  cfg_in.repeat_detect_enable = csr_write_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period_ticks     <= BIT_PERIOD_RESET;
         cfg_ff.half_bit_ticks       <= HALF_BIT_RESET;
         cfg_ff.tolerance_ticks      <= TOLERANCE_RESET;
         cfg_ff.repeat_detect_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/rc5d_step.sv */
// Module: next-state and result logic for one edge or timeout word.
`timescale 1ns / 1ps
`default_nettype none
module rc5d_step
   import rc5d_pkg::*;
(
   input  wire cfg_type       cfg,
   input  wire dec_state_type state_cur,
   input  wire req_word_type  word,
   output dec_state_type      state_nxt,
   output logic               frame_valid
);

   logic [COUNT_WIDTH:0]    sum;
   logic [COUNT_WIDTH-1:0]  cnt;
   logic                    near_full;
   logic                    near_half;
   logic [BITPOS_WIDTH-1:0] bitpos_inc;

   always_comb begin
      sum        = {1'b0, state_cur.tick_count} + {1'b0, word.elapsed_ticks};
      cnt        = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
      near_full  = near_value(cnt, cfg.bit_period_ticks, cfg.tolerance_ticks);
      near_half  = near_value(cnt, cfg.half_bit_ticks, cfg.tolerance_ticks);
      bitpos_inc = state_cur.bit_position + 1'b1;

      state_nxt            = state_cur;
      state_nxt.tick_count = cnt;
      frame_valid          = 1'b0;

      if (word.mode) begin
         state_nxt.phase = PHASE_START1;
      end else if (!(state_cur.phase inside {[PHASE_START2:PHASE_COMMAND]})) begin
         // idle: wait for the falling edge of the first start bit
         state_nxt.phase = PHASE_START1;
         if (word.line_low) begin
            state_nxt.phase      = PHASE_START2;
            state_nxt.tick_count = '0;
         end
      end else if (near_full) begin
         state_nxt.tick_count = '0;
         case (state_cur.phase)
            PHASE_START2: state_nxt.phase = PHASE_TOGGLE;
            PHASE_TOGGLE: begin
               state_nxt.previous_toggle = state_cur.current_toggle;
               state_nxt.current_toggle  = word.line_low;
               state_nxt.bit_position    = '0;
               state_nxt.address_shift   = '0;
               state_nxt.command_shift   = '0;
               state_nxt.phase           = PHASE_ADDRESS;
            end
            PHASE_ADDRESS: begin
               if (word.line_low)
                  state_nxt.address_shift = state_cur.address_shift |
                     ({1'b1, {(ADDRESS_BITS-1){1'b0}}} >> state_cur.bit_position);
               state_nxt.bit_position = bitpos_inc;
               if (bitpos_inc == ADDRESS_LAST) begin
                  state_nxt.bit_position = '0;
                  state_nxt.phase        = PHASE_COMMAND;
               end
            end
            default: begin
               if (word.line_low)
                  state_nxt.command_shift = state_cur.command_shift |
                     ({1'b1, {(COMMAND_BITS-1){1'b0}}} >> state_cur.bit_position);
               state_nxt.bit_position = bitpos_inc;
               if (bitpos_inc == COMMAND_LAST) begin
                  state_nxt.bit_position = '0;
                  if ((state_cur.current_toggle == state_cur.previous_toggle) &&
                      cfg.repeat_detect_enable) begin
                     state_nxt.repeats = state_cur.repeats + 1'b1;
                  end else begin
                     frame_valid       = 1'b1;
                     state_nxt.repeats = '0;
                  end
                  state_nxt.phase = PHASE_START1;
               end
            end
         endcase
      end else if (near_half) begin
         // mid-bit edge: resync the count to half a bit
         state_nxt.tick_count = cfg.half_bit_ticks;
      end else begin
         state_nxt.phase = PHASE_START1;
      end
   end

endmodule
`default_nettype wire

/* src/rc5_ir_edge_timing_decoder_core.sv */
// Top level: RC5 infrared decoder fed by receiver edge and timeout words.
//
// Usage notes:
//  - req_chan carries one word per line edge (mode 0, line_low = level after
//    the edge) or per timeout (mode 1), each with the ticks since the last word.
//  - rsp_chan returns exactly one word per request: frame_valid flags a new
//    (non-repeat) frame, the other fields show decoder state after the word.
//  - Both channels use valid/ready; a word moves when both are high.
//  - The request is captured in an input register, then the decode logic
//    updates the decoder state and loads the result register. Throughput
//    is one word per clock unless the receiver stalls; the decode logic is a
//    single pass of a saturating add and two window compares between those registers.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more word; after that req_chan.ready drops
//    until the result is taken. No word is dropped or repeated.
//  - csr_* writes take effect the cycle after csr_write_enable; write them
//    only while no word is in flight.
//  - Synchronous reset clears the decoder state, both pipeline registers'
//    valid flags and loads the default timing registers (1778/889/240, repeat
//    detection on).
`timescale 1ns / 1ps
`default_nettype none
module rc5_ir_edge_timing_decoder_core
   import rc5d_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   rc5d_req_if.sink                        req_chan,
   rc5d_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COUNT_WIDTH-1:0]     csr_write_data
);

   cfg_type       cfg;

   // input register
   logic          in_valid_ff;
   logic          in_valid_in;
   req_word_type  in_word_ff;
   req_word_type  in_word_in;

   // decoder state
   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type state_step;
   logic          frame_valid_step;

   // result register
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_frame_ff;
   logic          out_frame_in;

   logic          out_free;
   logic          advance;
   logic          take;

   rc5d_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rc5d_step u_step (
      .cfg         (cfg),
      .state_cur   (state_ff),
      .word        (in_word_ff),
      .state_nxt   (state_step),
      .frame_valid (frame_valid_step)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (advance)
         in_valid_in = 1'b0;
      if (take) begin
         in_valid_in            = 1'b1;
         in_word_in.mode          = req_chan.mode;
         in_word_in.line_low      = req_chan.line_low;
         in_word_in.elapsed_ticks = req_chan.elapsed_ticks;
      end

      state_in     = advance ? state_step : state_ff;
      out_frame_in = advance ? frame_valid_step : out_frame_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_word_ff   <= in_word_in;
      out_frame_ff <= out_frame_in;
   end

   // result fields mirror the decoder state loaded with the result word
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_valid   = out_frame_ff;
   assign rsp_chan.address       = state_ff.address_shift;
   assign rsp_chan.command       = state_ff.command_shift;
   assign rsp_chan.toggle_bit    = state_ff.current_toggle;
   assign rsp_chan.repeat_count  = state_ff.repeats;
   assign rsp_chan.decoder_phase = state_ff.phase;

endmodule
`default_nettype wire
